>>> rtl/cfq_pkg.sv
// Shared constants, codes and types for the circular FIFO queue.
package cfq_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int OCC_W  = 8;
	localparam int ST_W   = 2;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_ENQUEUE = 2'd0;
	localparam op_t OP_DEQUEUE = 2'd1;
	localparam op_t OP_SIZE    = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

>>> rtl/cfq_if.sv
// Request and response channel interfaces of the circular FIFO queue.
interface cfq_req_if import cfq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface cfq_rsp_if import cfq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic        [OCC_W-1:0]  occupancy;
	status_t                  status;

	modport source (output valid, output data, output occupancy, output status, input ready);
	modport sink (input valid, input data, input occupancy, input status, output ready);
endinterface

>>> rtl/cfq_cell.sv
// One storage cell of the queue: loads a new word or takes its neighbor's word.
module cfq_cell import cfq_pkg::*; (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic signed [DATA_W-1:0] nxt_data,
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= nxt_data;
		end else if (ctrl.load) begin
			data_q <= wr_data;
		end
	end

	assign data = data_q;

endmodule

>>> rtl/circular_fifo_queue.sv
// Circular FIFO queue top level: a row of cells shifting toward the head.
// The response word is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless rsp stalls; count and cells update in one step.
// A request is taken while the response register is empty or being drained.
// Reset clears the entry count and the response valid; cell contents stay undefined.
module circular_fifo_queue import cfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cfq_req_if.sink   req,
	cfq_rsp_if.source rsp
);

	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic [OCC_W-1:0]         occ_q;
	status_t                  status_q;

	logic                     acc;
	logic                     full;
	logic                     empty;
	logic                     enq_ok;
	logic                     deq_ok;
	logic [CNT_W-1:0]         count_nxt;
	status_t                  status_nxt;
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	cell_ctrl_t               cell_ctrl [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign enq_ok    = acc && (req.op == OP_ENQUEUE) && !full;
	assign deq_ok    = acc && (req.op == OP_DEQUEUE) && !empty;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (req.op == OP_ENQUEUE) begin
			if (full) begin
				status_nxt = ST_OVERFLOW;
			end else begin
				count_nxt = count_q + CNT_W'(1);
			end
		end else if (req.op == OP_DEQUEUE) begin
			if (empty) begin
				status_nxt = ST_UNDERFLOW;
			end else begin
				count_nxt = count_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] nxt;

		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		assign cell_ctrl[i].shift = deq_ok;
		assign cell_ctrl[i].load  = enq_ok && (count_q[IDX_W-1:0] == IDX_W'(i));

		cfq_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.wr_data  (req.value),
			.nxt_data (nxt),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_q   <= deq_ok ? cell_data[0] : '0;
			occ_q    <= OCC_W'(count_nxt);
			status_q <= status_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data      = data_q;
	assign rsp.occupancy = occ_q;
	assign rsp.status    = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp.valid)
		else $error("accepted request gave no response word");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_ENQUEUE && full) |=> (rsp.status == ST_OVERFLOW && $stable(count_q)))
		else $error("full enqueue not reported or changed count");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_DEQUEUE && empty) |=> (rsp.status == ST_UNDERFLOW && rsp.data == '0))
		else $error("empty dequeue not reported");
`endif

endmodule
